/* rtl/nfp_pkg.sv */
package nfp_pkg;

    localparam int LEN_W   = 16;
    localparam int STR_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int DCNT_W  = 4;
    localparam int ACC_X_W = LEN_W + 4;

    localparam logic [DCNT_W-1:0] DIGIT_LIMIT = 4'd10;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RST  = 16'd4096;
    localparam logic [STR_W-1:0] MAX_STRINGS_RST = 8'd64;

    localparam logic CFG_MAX_LENGTH  = 1'b0;
    localparam logic CFG_MAX_STRINGS = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_INVALID_SIZE = 3'd1,
        ERR_NO_COLON     = 3'd2,
        ERR_TRUNCATED    = 3'd3,
        ERR_NO_COMMA     = 3'd4,
        ERR_TOO_MANY     = 3'd5
    } t_nfp_err;

    typedef struct packed {
        logic              eos;
        logic [BYTE_W-1:0] data;
        logic              is_digit;
        logic              is_colon;
        logic              is_comma;
        logic              is_nul;
        logic [3:0]        digit;
    } t_nfp_cmd;

    typedef struct packed {
        logic [LEN_W-1:0] max_length;
        logic [STR_W-1:0] max_strings;
    } t_nfp_cfg;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              string_end;
        logic [STR_W-1:0]  string_index;
        logic              frame_done;
        logic [LEN_W-1:0]  frame_length;
        t_nfp_err          error_code;
    } t_nfp_res;

endpackage

/* rtl/nfp_if.sv */
interface nfp_req_if;
    import nfp_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;
    modport source (output valid, opcode, data_byte, input ready);
    modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface nfp_res_if;
    import nfp_pkg::*;
    logic              valid;
    logic              ready;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              string_end;
    logic [STR_W-1:0]  string_index;
    logic              frame_done;
    logic [LEN_W-1:0]  frame_length;
    logic [2:0]        error_code;
    modport source (output valid, payload_valid, payload_byte, string_end, string_index,
                    frame_done, frame_length, error_code, input ready);
    modport sink   (input valid, payload_valid, payload_byte, string_end, string_index,
                    frame_done, frame_length, error_code, output ready);
endinterface

interface nfp_cfg_if;
    import nfp_pkg::*;
    logic             valid;
    logic             ready;
    logic             index;
    logic [LEN_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/nfp_front.sv */
module nfp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nfp_req_if.sink           i_req,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output nfp_pkg::t_nfp_cmd o_cmd
);
    import nfp_pkg::*;

    t_nfp_cmd   r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    t_nfp_cmd   w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd          = '0;
        w_cmd.eos      = i_req.opcode;
        w_cmd.data     = i_req.data_byte;
        w_cmd.is_digit = (i_req.data_byte >= CH_ZERO) && (i_req.data_byte <= CH_NINE);
        w_cmd.is_colon = (i_req.data_byte == CH_COLON);
        w_cmd.is_comma = (i_req.data_byte == CH_COMMA);
        w_cmd.is_nul   = (i_req.data_byte == CH_NUL);
        w_cmd.digit    = 4'(i_req.data_byte - CH_ZERO);
    end

    assign i_req.ready = (r_count != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

/* rtl/nfp_back.sv */
module nfp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  nfp_pkg::t_nfp_cmd i_cmd,
    input  nfp_pkg::t_nfp_cfg i_cfg,
    nfp_res_if.source         o_res
);
    import nfp_pkg::*;

    typedef enum logic [1:0] {
        PH_DIGITS  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_COMMA   = 2'd2,
        PH_DISCARD = 2'd3
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [LEN_W-1:0]    r_acc, n_acc;
    logic [DCNT_W-1:0]   r_digits, n_digits;
    logic [LEN_W-1:0]    r_remain, n_remain;
    logic [STR_W-1:0]    r_strcnt, n_strcnt;
    t_nfp_res            r_res, n_res;
    logic                r_out_valid;
    logic [ACC_X_W-1:0]  w_next_len;
    logic                w_fire;

    assign o_cmd_ready = !r_out_valid || o_res.ready;
    assign w_fire      = i_cmd_valid && o_cmd_ready;
    assign w_next_len  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                       + {{(ACC_X_W-4){1'b0}}, i_cmd.digit};

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_digits = r_digits;
        n_remain = r_remain;
        n_strcnt = r_strcnt;
        n_res    = '0;
        if (i_cmd.eos) begin
            if (r_phase == PH_PAYLOAD || r_phase == PH_COMMA ||
                (r_phase == PH_DIGITS && r_digits != '0)) begin
                n_res.error_code = ERR_TRUNCATED;
            end
            n_phase  = PH_DIGITS;
            n_acc    = '0;
            n_digits = '0;
            n_remain = '0;
            n_strcnt = '0;
        end else begin
            unique case (r_phase)
                PH_DIGITS: begin
                    if (i_cmd.is_digit) begin
                        if (r_digits >= DIGIT_LIMIT ||
                            w_next_len > {4'b0, i_cfg.max_length}) begin
                            n_res.error_code = ERR_INVALID_SIZE;
                            n_phase          = PH_DISCARD;
                        end else begin
                            n_acc    = w_next_len[LEN_W-1:0];
                            n_digits = r_digits + DCNT_W'(1);
                        end
                    end else if (i_cmd.is_colon) begin
                        if (r_digits == '0) begin
                            n_res.error_code = ERR_INVALID_SIZE;
                            n_phase          = PH_DISCARD;
                        end else begin
                            n_remain = r_acc;
                            n_phase  = (r_acc == '0) ? PH_COMMA : PH_PAYLOAD;
                        end
                    end else begin
                        n_res.error_code = ERR_NO_COLON;
                        n_phase          = PH_DISCARD;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_strcnt >= i_cfg.max_strings) begin
                        n_res.error_code = ERR_TOO_MANY;
                        n_phase          = PH_DISCARD;
                    end else begin
                        n_res.payload_valid = 1'b1;
                        n_res.payload_byte  = i_cmd.data;
                        n_res.string_index  = r_strcnt;
                        if (i_cmd.is_nul) begin
                            n_res.string_end = 1'b1;
                            n_strcnt         = r_strcnt + STR_W'(1);
                        end
                        n_remain = r_remain - LEN_W'(1);
                        if (r_remain == LEN_W'(1)) begin
                            n_phase = PH_COMMA;
                        end
                    end
                end
                PH_COMMA: begin
                    if (i_cmd.is_comma) begin
                        n_res.frame_done   = 1'b1;
                        n_res.frame_length = r_acc;
                        n_phase            = PH_DIGITS;
                        n_acc              = '0;
                        n_digits           = '0;
                        n_remain           = '0;
                        n_strcnt           = '0;
                    end else begin
                        n_res.error_code = ERR_NO_COMMA;
                        n_phase          = PH_DISCARD;
                    end
                end
                PH_DISCARD: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DIGITS;
            r_acc       <= '0;
            r_digits    <= '0;
            r_remain    <= '0;
            r_strcnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_digits <= n_digits;
                r_remain <= n_remain;
                r_strcnt <= n_strcnt;
                r_res    <= n_res;
            end
            if (o_cmd_ready) begin
                r_out_valid <= i_cmd_valid;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.payload_valid = r_res.payload_valid;
    assign o_res.payload_byte  = r_res.payload_byte;
    assign o_res.string_end    = r_res.string_end;
    assign o_res.string_index  = r_res.string_index;
    assign o_res.frame_done    = r_res.frame_done;
    assign o_res.frame_length  = r_res.frame_length;
    assign o_res.error_code    = r_res.error_code;

endmodule

/* rtl/netstring_frame_parser_top.sv */
// Channel   Dir  Fields                                                 Accepted when
// i_req     in   opcode, data_byte                                      valid && ready
// o_res     out  payload_valid, payload_byte, string_end, string_index, valid && ready
//                frame_done, frame_length, error_code
// i_cfg     in   index (0 max_length, 1 max_strings), data              valid && ready
//
// One request per cycle while results are taken; a request passes the queue, then the registered parser.
// The parser handles each byte in one combinational step (length multiply-add by ten).
// A two-entry queue sits between classifier and parser; each side stalls on its own.
// Synchronous active-low reset clears the parser and restores the register defaults.
// Config writes are always ready.
module netstring_frame_parser_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    nfp_req_if.sink  i_req,
    nfp_res_if.source o_res,
    nfp_cfg_if.sink  i_cfg
);
    import nfp_pkg::*;

    t_nfp_cfg r_cfg;
    t_nfp_cmd w_cmd;
    logic     w_cmd_valid, w_cmd_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_length  <= MAX_LENGTH_RST;
            r_cfg.max_strings <= MAX_STRINGS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAX_LENGTH:  r_cfg.max_length  <= i_cfg.data;
                CFG_MAX_STRINGS: r_cfg.max_strings <= i_cfg.data[STR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    nfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    nfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .o_res       (o_res)
    );

endmodule

/* rtl/nfp_checker.sv */
module nfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_payload_valid,
    input logic [7:0]  i_payload_byte,
    input logic        i_string_end,
    input logic [7:0]  i_string_index,
    input logic        i_frame_done,
    input logic [15:0] i_frame_length,
    input logic [2:0]  i_error_code
);
    import nfp_pkg::*;

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_payload_valid |-> i_payload_byte == '0 && i_string_index == '0
                                        && !i_string_end)
        else $error("non-payload result carries payload fields");

    a_done_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_done |-> !i_payload_valid && i_error_code == ERR_NONE)
        else $error("frame done together with payload or error");

    a_length_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_frame_done |-> i_frame_length == '0)
        else $error("frame length without frame done");

    a_error_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error_code != ERR_NONE |-> !i_payload_valid)
        else $error("error result carries payload");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_payload_byte)
                                && $stable(i_error_code) && $stable(i_frame_length))
        else $error("stalled result changed");

endmodule

bind netstring_frame_parser_top nfp_checker u_nfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_payload_valid (o_res.payload_valid),
    .i_payload_byte  (o_res.payload_byte),
    .i_string_end    (o_res.string_end),
    .i_string_index  (o_res.string_index),
    .i_frame_done    (o_res.frame_done),
    .i_frame_length  (o_res.frame_length),
    .i_error_code    (o_res.error_code)
);

/* test/nfp_frame_checker.sv */
module nfp_frame_checker
    import nfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    nfp_req_if   req,
    nfp_res_if   res,
    nfp_cfg_if   cfg,
    output int   o_fail_cnt,
    output int   o_pending,
    output int   o_checked,
    output int   o_frames,
    output int   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {PH_DIGITS, PH_PAYLOAD, PH_COMMA, PH_DISCARD} t_phase;

    t_phase           phase;
    logic [16:0]      len_acc;
    logic [3:0]       n_digits;
    logic [LEN_W-1:0] remain;
    logic [STR_W-1:0] str_no;
    logic [LEN_W-1:0] lim_len;
    logic [STR_W-1:0] lim_str;
    t_nfp_res         due_results[$];

    function automatic void restart_frame();
        phase    = PH_DIGITS;
        len_acc  = '0;
        n_digits = '0;
        remain   = '0;
        str_no   = '0;
    endfunction

    function automatic t_nfp_res parse_step(input logic eos, input logic [BYTE_W-1:0] b);
        t_nfp_res    r;
        int unsigned v;
        r = '0;
        if (eos) begin
            if (phase == PH_PAYLOAD || phase == PH_COMMA ||
                (phase == PH_DIGITS && n_digits != 0)) begin
                r.error_code = ERR_TRUNCATED;
            end
            restart_frame();
            return r;
        end
        case (phase)
            PH_DIGITS: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    v = len_acc * 10 + (b - CH_ZERO);
                    if (n_digits >= DIGIT_LIMIT || v > lim_len) begin
                        r.error_code = ERR_INVALID_SIZE;
                        phase = PH_DISCARD;
                    end else begin
                        len_acc = v[16:0];
                        n_digits++;
                    end
                end else if (b == CH_COLON) begin
                    if (n_digits == 0) begin
                        r.error_code = ERR_INVALID_SIZE;
                        phase = PH_DISCARD;
                    end else begin
                        remain = len_acc[LEN_W-1:0];
                        if (remain == 0) begin
                            phase = PH_COMMA;
                        end else begin
                            phase = PH_PAYLOAD;
                        end
                    end
                end else begin
                    r.error_code = ERR_NO_COLON;
                    phase = PH_DISCARD;
                end
            end
            PH_PAYLOAD: begin
                if (str_no >= lim_str) begin
                    r.error_code = ERR_TOO_MANY;
                    phase = PH_DISCARD;
                end else begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.string_index  = str_no;
                    if (b == CH_NUL) begin
                        r.string_end = 1'b1;
                        str_no++;
                    end
                    remain--;
                    if (remain == 0) begin
                        phase = PH_COMMA;
                    end
                end
            end
            PH_COMMA: begin
                if (b == CH_COMMA) begin
                    r.frame_done   = 1'b1;
                    r.frame_length = len_acc[LEN_W-1:0];
                    restart_frame();
                end else begin
                    r.error_code = ERR_NO_COMMA;
                    phase = PH_DISCARD;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : p_check
        t_nfp_res want;
        if (!i_rst_n) begin
            lim_len = MAX_LENGTH_RST;
            lim_str = MAX_STRINGS_RST;
            restart_frame();
            due_results.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == CFG_MAX_LENGTH) begin
                    lim_len = cfg.data;
                end else begin
                    lim_str = cfg.data[STR_W-1:0];
                end
            end
            if (req.valid && req.ready) begin
                due_results.push_back(parse_step(req.opcode, req.data_byte));
            end
            if (res.valid && res.ready) begin
                o_checked++;
                if (res.frame_done === 1'b1) o_frames++;
                if (res.error_code != ERR_NONE) o_errors++;
                if (due_results.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_cnt++;
                end else begin
                    want = due_results.pop_front();
                    check_field("payload_valid", want.payload_valid, res.payload_valid);
                    check_field("payload_byte", want.payload_byte, res.payload_byte);
                    check_field("string_end", want.string_end, res.string_end);
                    check_field("string_index", want.string_index, res.string_index);
                    check_field("frame_done", want.frame_done, res.frame_done);
                    check_field("frame_length", want.frame_length, res.frame_length);
                    check_field("error_code", want.error_code, res.error_code);
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nfp_pkg::*;

    localparam int ITEMS_TARGET = 650;
    localparam int N_SETTINGS   = 7;
    localparam int PRESSURE_SET = 2;
    localparam int HOLD_LEN     = 120;
    localparam int CYCLE_LIMIT  = 400000;

    // 0 picks a random value
    localparam int unsigned SET_LEN [N_SETTINGS] = '{65535, 1, 9, 300, 0, 65535, 40};
    localparam int unsigned SET_STR [N_SETTINGS] = '{255, 1, 2, 3, 0, 1, 255};

    logic clk = 1'b0;
    logic rst_n;
    int   cycles;
    int   n_sent;
    int   req_gap_pct;
    int   rdy_gap_pct;
    int   hold_cycles;
    int   fail_cnt, pending, checked, frames, errors;
    int unsigned lim_len = MAX_LENGTH_RST;
    int unsigned lim_str = MAX_STRINGS_RST;

    nfp_req_if req_ch();
    nfp_res_if res_ch();
    nfp_cfg_if cfg_ch();

    netstring_frame_parser_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    nfp_frame_checker chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .cfg        (cfg_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_frames   (frames),
        .o_errors   (errors)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("run exceeded %0d cycles", CYCLE_LIMIT);
            $display("FAIL netstring_frame_parser_top");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end else if (rdy_gap_pct > 0 && $urandom_range(1, 100) <= rdy_gap_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    function automatic int ndig(input int unsigned n);
        int c;
        c = 1;
        while (n >= 10) begin
            n = n / 10;
            c++;
        end
        return c;
    endfunction

    function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] rand_payload();
        return ($urandom_range(0, 4) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_junk();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
        return b;
    endfunction

    task automatic put_req(input logic op, input logic [7:0] b);
        if (req_gap_pct > 0 && $urandom_range(1, 100) <= req_gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.data_byte <= b;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        n_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_req(1'b0, b);
    endtask

    task automatic put_eos();
        put_req(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic put_len(input int unsigned n, input int zeros);
        logic [7:0]  dig[$];
        int unsigned x;
        x = n;
        do begin
            dig.push_front(8'(CH_ZERO + x % 10));
            x = x / 10;
        end while (x != 0);
        repeat (zeros) put_byte(CH_ZERO);
        foreach (dig[i]) put_byte(dig[i]);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [LEN_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic run_frame();
        int unsigned len, nul_cnt, k;
        int          kind;
        logic [7:0]  b;
        bit          bad;
        kind = $urandom_range(0, 99);
        bad  = 1'b0;
        if (kind < 55) begin
            // well-formed frame, possibly tripping the string limit
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, min_u(lim_len, 64))
                                              : $urandom_range(0, min_u(lim_len, 10));
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10 - ndig(len)) : 0;
            put_len(len, k);
            put_byte(CH_COLON);
            nul_cnt = 0;
            for (int i = 0; i < len; i++) begin
                b = rand_payload();
                if (nul_cnt >= lim_str) bad = 1'b1;
                if (b == CH_NUL) nul_cnt++;
                put_byte(b);
            end
            if (!bad) begin
                if ($urandom_range(0, 9) == 0) begin
                    b = rand_junk();
                    if (b == CH_COMMA) b = CH_NUL;
                    put_byte(b);
                    bad = 1'b1;
                end else begin
                    put_byte(CH_COMMA);
                end
            end
            if (bad || $urandom_range(0, 6) == 0) put_eos();
        end else if (kind < 65) begin
            len = $urandom_range(1, min_u(lim_len, 10));
            put_len(len, 0);
            if ($urandom_range(0, 1) == 1) begin
                put_byte(CH_COLON);
                k = $urandom_range(0, len - 1);
                repeat (k) put_byte(rand_payload());
            end
            put_eos();
        end else if (kind < 70) begin
            // digit count overflow
            len = $urandom_range(0, min_u(lim_len, 9));
            put_len(len, 10 - ndig(len));
            repeat ($urandom_range(1, 2)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            put_eos();
        end else if (kind < 77) begin
            if ($urandom_range(0, 1) == 1) begin
                put_len(lim_len + 1 + $urandom_range(0, 50000), 0);
            end else begin
                put_len($urandom_range(100000, 32'hFFFF_FFFF), 0);
            end
            if ($urandom_range(0, 1) == 1) put_byte(CH_COLON);
            put_eos();
        end else if (kind < 84) begin
            repeat ($urandom_range(0, 3)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            put_byte(rand_junk());
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
            put_eos();
        end else if (kind < 87) begin
            put_byte(CH_COLON);
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
            put_eos();
        end else if (kind < 93) begin
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
            put_eos();
        end else begin
            put_eos();
        end
    endtask

    initial begin
        int phase_end;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= 1'b0;
        req_ch.data_byte <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_MAX_LENGTH;
        cfg_ch.data      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests under the reset limits
        req_gap_pct = 15;
        rdy_gap_pct = 15;
        put_eos();
        put_byte(CH_ZERO); put_byte(CH_COLON); put_byte(CH_COMMA);
        put_byte("2"); put_byte(CH_COLON); put_byte(CH_NUL); put_byte(8'hFF);
        put_byte(CH_COMMA);
        put_byte(CH_COLON); put_byte(8'hFF); put_eos();
        put_byte(8'h80); put_eos();
        put_byte("1"); put_byte(CH_COLON); put_byte("a"); put_byte(";"); put_eos();
        put_byte("1"); put_byte("2"); put_req(1'b1, 8'hFF);
        put_len(5000, 0); put_eos();

        for (int s = 0; s < N_SETTINGS; s++) begin
            drain();
            lim_len = (SET_LEN[s] == 0) ? $urandom_range(1, 65535) : SET_LEN[s];
            lim_str = (SET_STR[s] == 0) ? $urandom_range(1, 255) : SET_STR[s];
            write_reg(CFG_MAX_LENGTH, LEN_W'(lim_len));
            write_reg(CFG_MAX_STRINGS, LEN_W'(lim_str));
            cfg_ch.valid <= 1'b0;
            if (s == N_SETTINGS - 1) begin
                req_gap_pct = 0;
                rdy_gap_pct = 0;
            end else if (s == PRESSURE_SET) begin
                req_gap_pct = 0;
                rdy_gap_pct = 10;
                hold_cycles = HOLD_LEN;
            end else begin
                req_gap_pct = 12 * $urandom_range(0, 2);
                rdy_gap_pct = 12 * $urandom_range(0, 2);
            end
            phase_end = n_sent + (ITEMS_TARGET - n_sent) / (N_SETTINGS - s);
            while (n_sent < phase_end) run_frame();
            put_eos();
        end
        drain();

        $display("%0d requests over %0d limit settings, %0d results checked",
                 n_sent, N_SETTINGS + 1, checked);
        $display("%0d frames completed, %0d error results", frames, errors);
        if (fail_cnt == 0 && pending == 0) begin
            $display("PASS netstring_frame_parser_top");
        end else begin
            $display("FAIL netstring_frame_parser_top");
        end
        $finish;
    end

endmodule
